// ----- hdl/escape_byte_stuffing_codec_defines.svh -----
// Assertion macros shared by the escape codec checker.
`ifndef ESCAPE_BYTE_STUFFING_CODEC_DEFINES_SVH
`define ESCAPE_BYTE_STUFFING_CODEC_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define EBSC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("escape codec: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define EBSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("escape codec: next-cycle check failed");

`endif

// ----- hdl/ebsc_pkg.sv -----
// Shared types and constants for the escape byte-stuffing codec.
package ebsc_pkg;

  localparam logic [7:0] EscByte  = 8'hF0;
  localparam logic [3:0] EscNibble = 4'hF;

  // One output byte with its frame marker
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } result_t;

  // Outcome of converting one input byte
  typedef struct packed {
    logic [1:0] n_res;      // number of result bytes, 0..2
    result_t    res0;
    result_t    res1;
    logic       pend_d;     // next value of the held-escape flag
  } xform_t;

endpackage

// ----- hdl/ebsc_xform.sv -----
// Combinational escape / unescape of one input byte.
module ebsc_xform (
  input  logic                  decode_mode_i,
  input  logic                  pending_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  frame_end_i,
  output ebsc_pkg::xform_t      xf_o
);
  import ebsc_pkg::*;

  logic hi_esc;
  logic hi_zero;

  assign hi_esc  = (data_byte_i[7:4] == EscNibble);
  assign hi_zero = (data_byte_i[7:4] == 4'h0);

  always_comb begin
    xf_o        = '0;
    xf_o.pend_d = 1'b0;
    if (!decode_mode_i) begin
      // transmit: F-class bytes split into escape plus low nibble
      if (hi_esc) begin
        xf_o.n_res = 2'd2;
        xf_o.res0  = '{out_byte: EscByte, out_last: 1'b0};
        xf_o.res1  = '{out_byte: {4'h0, data_byte_i[3:0]}, out_last: frame_end_i};
      end else begin
        xf_o.n_res = 2'd1;
        xf_o.res0  = '{out_byte: data_byte_i, out_last: frame_end_i};
      end
    end else if (pending_i && hi_zero) begin
      // receive: held escape merges with a low-nibble byte
      xf_o.n_res = 2'd1;
      xf_o.res0  = '{out_byte: EscByte | data_byte_i, out_last: frame_end_i};
    end else begin
      // receive: flush any held escape, then take the byte afresh
      if (pending_i) begin
        xf_o.res0 = '{out_byte: EscByte, out_last: 1'b0};
      end
      if ((data_byte_i == EscByte) && !frame_end_i) begin
        xf_o.pend_d = 1'b1;
        xf_o.n_res  = {1'b0, pending_i};
      end else if (pending_i) begin
        xf_o.res1  = '{out_byte: data_byte_i, out_last: frame_end_i};
        xf_o.n_res = 2'd2;
      end else begin
        xf_o.res0  = '{out_byte: data_byte_i, out_last: frame_end_i};
        xf_o.n_res = 2'd1;
      end
    end
  end

endmodule

// ----- hdl/escape_byte_stuffing_codec.sv -----
// Escape byte-stuffing codec: top level with output queue and mode register.
// First result byte is registered: valid in the cycle after the input transaction.
// One input per cycle if each gives one byte and output is not stalled; two-byte ones hold input.
// Rate set by the two-entry result queue: input is taken when it is empty or its last byte leaves.
// Reset clears the mode to encode, drops any held escape and empties the queue.
module escape_byte_stuffing_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,       // decode_mode
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,     // [7:0] data_byte
  input  logic       s_axis_tlast,     // frame_end
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,     // [7:0] out_byte
  output logic       m_axis_tlast      // out_last
);
  import ebsc_pkg::*;

  logic       mode_q;
  logic       pend_q, pend_d;
  logic [1:0] cnt_q, cnt_d;
  result_t    buf_q [2];
  result_t    buf_d [2];
  xform_t     xf;
  logic       pop, acc, cfg_wr;

  ebsc_xform u_xform (
    .decode_mode_i (mode_q),
    .pending_i     (pend_q),
    .data_byte_i   (s_axis_tdata),
    .frame_end_i   (s_axis_tlast),
    .xf_o          (xf)
  );

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign cfg_wr        = cfg_valid_i;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready);
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = buf_q[0].out_byte;
  assign m_axis_tlast  = buf_q[0].out_last;

  // result queue update: pop the head, then load a fresh transaction
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (pop) begin
      buf_d[0] = buf_q[1];
      cnt_d    = cnt_q - 2'd1;
    end
    if (acc) begin
      buf_d[0] = xf.res0;
      buf_d[1] = xf.res1;
      cnt_d    = xf.n_res;
    end
  end

  // held escape: a mode write discards it
  always_comb begin
    pend_d = pend_q;
    if (cfg_wr) begin
      pend_d = 1'b0;
    end else if (acc) begin
      pend_d = xf.pend_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      pend_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (cfg_wr) begin
        mode_q <= cfg_data_i;
      end
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue payload
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

// ----- hdl/ebsc_checker.sv -----
// Port-level checker for the escape codec, bound to the top level.
`include "escape_byte_stuffing_codec_defines.svh"

module ebsc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic       cfg_data_i,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);
  import ebsc_pkg::*;

  logic mode_q;
  logic s_acc;
  logic enc_split;
  logic enc_pass;

  // shadow of the mode register, seen from the configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign enc_split = s_acc && !mode_q && (s_axis_tdata[7:4] == EscNibble);
  assign enc_pass  = s_acc && !mode_q && (s_axis_tdata[7:4] != EscNibble);

  `EBSC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `EBSC_ASSERT_NOW(a_no_take_when_stalled, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `EBSC_ASSERT_NEXT(a_enc_escape_first, enc_split, m_axis_tvalid && (m_axis_tdata == EscByte) && !m_axis_tlast)
  `EBSC_ASSERT_NEXT(a_enc_pass, enc_pass, m_axis_tvalid && (m_axis_tdata == $past(s_axis_tdata)) && (m_axis_tlast == $past(s_axis_tlast)))

endmodule

bind escape_byte_stuffing_codec ebsc_checker u_ebsc_checker (.*);

// ----- sim/testbench.sv -----
// Self-checking stream testbench for the escape byte-stuffing codec.
`timescale 1ns / 1ps

module testbench;
  import ebsc_pkg::*;

  localparam bit ModeEncode = 1'b0;
  localparam bit ModeDecode = 1'b1;
  localparam int HoldCycles = 300;
  localparam int PhaseItems = 170;

  typedef struct {
    logic [7:0] octet;
    logic       fin;
  } frame_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  escape_byte_stuffing_codec u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Stimulus waiting to be sent, and converted bytes still owed by the block
  frame_byte_t tx_bytes[$];
  result_t     owed_bytes[$];

  // Shadow of the codec state
  bit mode_q;
  bit esc_held;

  int mismatches;
  bit in_done, out_done, presenting, in_burst, out_burst, hold_req;
  int gap_left, stall_left, hold_left;
  frame_byte_t cur;

  function automatic void owe(logic [7:0] b, logic l);
    result_t r;
    r.out_byte = b;
    r.out_last = l;
    owed_bytes.push_back(r);
  endfunction

  // Expected output bytes for one accepted input byte
  function automatic void convert_byte(logic [7:0] b, logic l);
    if (mode_q == ModeEncode) begin
      esc_held = 1'b0;
      if (b[7:4] == EscNibble) begin
        owe(EscByte, 1'b0);
        owe({4'h0, b[3:0]}, l);
      end else begin
        owe(b, l);
      end
      return;
    end
    if (esc_held) begin
      esc_held = 1'b0;
      if (b[7:4] == 4'h0) begin
        owe(EscByte | {4'h0, b[3:0]}, l);
        return;
      end
      owe(EscByte, 1'b0);
    end
    // a fresh escape is held unless it closes the frame
    if (b == EscByte && !l) esc_held = 1'b1;
    else owe(b, l);
  endfunction

  // Input transactions feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      convert_byte(s_axis_tdata, s_axis_tlast);
      in_done = 1'b1;
    end
  end

  // Source: presents queued bytes with random gaps
  always @(negedge clk_i) begin
    if (in_done) begin
      in_done = 1'b0;
      presenting = 1'b0;
      if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
      gap_left = in_burst ? 0 : $urandom_range(0, 9);
    end
    if (!presenting) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (tx_bytes.size() != 0) begin
        cur = tx_bytes.pop_front();
        presenting = 1'b1;
      end
    end
    s_axis_tvalid <= presenting;
    s_axis_tdata  <= cur.octet;
    s_axis_tlast  <= cur.fin;
  end

  // Long receiver hold-off, counted here on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
  end

  // Sink: random back-pressure
  always @(negedge clk_i) begin
    if (out_done) begin
      out_done = 1'b0;
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      stall_left = out_burst ? 0 : $urandom_range(0, 9);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (hold_left == 0);
    end
  end

  // Output transactions checked against the oldest owed byte
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      out_done = 1'b1;
      if (owed_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output byte %h last %b", m_axis_tdata, m_axis_tlast);
      end else begin
        want = owed_bytes.pop_front();
        if (want.out_byte !== m_axis_tdata || want.out_last !== m_axis_tlast) begin
          mismatches++;
          if (mismatches <= 10)
            $display("output mismatch: expected %h last %b, got %h last %b",
                     want.out_byte, want.out_last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  task automatic send(logic [7:0] b, logic l);
    frame_byte_t fb;
    fb.octet = b;
    fb.fin = l;
    tx_bytes.push_back(fb);
  endtask

  // Wait until everything sent has been converted, plus a margin for held escapes
  task automatic drain();
    while (tx_bytes.size() != 0 || presenting || owed_bytes.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_mode(bit m);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mode_q = m;
    esc_held = 1'b0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Random frames: in decode mode F-class bytes mostly go as well-formed escape pairs, else raw
  task automatic random_frames(bit dec, int count);
    frame_byte_t fr[$];
    frame_byte_t fb;
    logic [7:0] raw;
    int len, sent;
    sent = 0;
    while (sent < count) begin
      fr.delete();
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0:       raw = {EscNibble, 4'($urandom_range(0, 15))};
          1:       raw = EscByte;
          default: raw = 8'($urandom);
        endcase
        fb.fin = 1'b0;
        if (dec && raw[7:4] == EscNibble && $urandom_range(0, 9) < 8) begin
          fb.octet = EscByte;
          fr.push_back(fb);
          fb.octet = {4'h0, raw[3:0]};
        end else begin
          fb.octet = raw;
        end
        fr.push_back(fb);
      end
      fr[fr.size() - 1].fin = 1'b1;
      foreach (fr[i]) tx_bytes.push_back(fr[i]);
      sent += fr.size();
      // keep the source queue short so drains stay brief
      while (tx_bytes.size() > 16) @(posedge clk_i);
    end
    drain();
  endtask

  initial begin
    bit phase_mode[6];
    phase_mode = '{ModeDecode, ModeEncode, ModeDecode, ModeDecode, ModeEncode, ModeDecode};
    mode_q = ModeEncode;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Encode: extremes, escape class and plain bytes
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    send(8'hF0, 1'b0);
    send(8'h0F, 1'b0);
    send(8'hEF, 1'b0);
    send(8'hFA, 1'b1);
    send(8'h7F, 1'b0);
    send(8'h80, 1'b1);
    drain();

    // Decode: pair, re-held escape, bad follower, escape closing a frame
    write_mode(ModeDecode);
    send(EscByte, 1'b0);
    send(8'h05, 1'b0);
    send(EscByte, 1'b0);
    send(EscByte, 1'b0);
    send(8'h0A, 1'b0);
    send(EscByte, 1'b0);
    send(8'h10, 1'b0);
    send(EscByte, 1'b1);
    send(EscByte, 1'b0);
    send(8'h3C, 1'b1);
    send(EscByte, 1'b0);
    send(EscByte, 1'b1);
    send(8'hFF, 1'b0);
    send(8'h00, 1'b1);
    send(EscByte, 1'b0);
    drain();

    // A mode write drops the held escape
    write_mode(ModeDecode);
    send(8'h05, 1'b1);
    drain();

    foreach (phase_mode[p]) begin
      write_mode(phase_mode[p]);
      if (p == 1 || p == 3) hold_req = 1'b1;
      random_frames(phase_mode[p], PhaseItems);
    end
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) $display("escape_byte_stuffing_codec regression: pass");
    else $display("escape_byte_stuffing_codec regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("escape_byte_stuffing_codec regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ebsc_pkg.sv
hdl/ebsc_xform.sv
hdl/escape_byte_stuffing_codec.sv
hdl/ebsc_checker.sv
sim/testbench.sv
